// ===== design/csvt_pkg.sv =====
`timescale 1ns / 1ps
// csv tokenizer shared types, byte codes and parse mode codes
package csvt_pkg;

    localparam int unsigned MAX_COLUMN_INDEX = 1023;
    localparam int unsigned COL_W = 10;
    localparam int unsigned COL_LIMIT_INT =
        (MAX_COLUMN_INDEX > ((1 << COL_W) - 1)) ? ((1 << COL_W) - 1) : MAX_COLUMN_INDEX;
    localparam logic [COL_W-1:0] COL_LIMIT = COL_LIMIT_INT[COL_W-1:0];

    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam int unsigned MODE_W = 3;
    localparam logic [MODE_W-1:0] M_REC_START  = 3'd0;
    localparam logic [MODE_W-1:0] M_FLD_START  = 3'd1;
    localparam logic [MODE_W-1:0] M_IN_TEXT    = 3'd2;
    localparam logic [MODE_W-1:0] M_QUOTED     = 3'd3;
    localparam logic [MODE_W-1:0] M_QUOTE_SEEN = 3'd4;
    localparam logic [MODE_W-1:0] M_AFTER_CR   = 3'd5;

    typedef struct packed {
        logic             has;
        logic             byte_valid;
        logic [7:0]       field_byte;
        logic             field_done;
        logic             record_done;
        logic [COL_W-1:0] column_index;
    } result_t;

endpackage

// ===== design/csvt_step.sv =====
`timescale 1ns / 1ps
// csv tokenizer per-byte parse step: next mode, next column and result word
module csvt_step (
    input  logic [csvt_pkg::MODE_W-1:0] mode,
    input  logic [csvt_pkg::COL_W-1:0]  column,
    input  logic [7:0]                  delimiter,
    input  logic [7:0]                  text_byte,
    input  logic                        is_final,
    output logic [csvt_pkg::MODE_W-1:0] mode_next,
    output logic [csvt_pkg::COL_W-1:0]  column_next,
    output csvt_pkg::result_t           result
);

    logic [csvt_pkg::MODE_W-1:0] mode_eff;
    logic                        skip_lf;
    logic                        is_quote;
    logic [csvt_pkg::COL_W-1:0]  column_inc;

    // plain text handling
    logic [csvt_pkg::MODE_W-1:0] txt_mode;
    logic [csvt_pkg::COL_W-1:0]  txt_column;
    csvt_pkg::result_t           txt_res;
    csvt_pkg::result_t           put_res;
    csvt_pkg::result_t           none_res;

    logic [csvt_pkg::MODE_W-1:0] step_mode;
    logic [csvt_pkg::COL_W-1:0]  step_column;
    csvt_pkg::result_t           step_res;

    assign is_quote   = (text_byte == csvt_pkg::QUOTE_BYTE);
    assign column_inc = (column < csvt_pkg::COL_LIMIT) ? column + 1'b1 : column;

    always_comb begin
        none_res = '0;
        put_res = '0;
        put_res.has = 1'b1;
        put_res.byte_valid = 1'b1;
        put_res.field_byte = text_byte;
        put_res.column_index = column;
    end

    always_comb begin
        txt_res = '0;
        txt_res.has = 1'b1;
        txt_res.column_index = column;
        priority if (text_byte == delimiter) begin
            txt_res.field_done = 1'b1;
            txt_column = column_inc;
            txt_mode = csvt_pkg::M_FLD_START;
        end else if (text_byte == csvt_pkg::CR_BYTE) begin
            txt_res.field_done = 1'b1;
            txt_res.record_done = 1'b1;
            txt_column = '0;
            txt_mode = csvt_pkg::M_AFTER_CR;
        end else if (text_byte == csvt_pkg::LF_BYTE) begin
            txt_res.field_done = 1'b1;
            txt_res.record_done = 1'b1;
            txt_column = '0;
            txt_mode = csvt_pkg::M_REC_START;
        end else begin
            txt_res = put_res;
            txt_column = column;
            txt_mode = csvt_pkg::M_IN_TEXT;
        end
    end

    // lf right after a record-ending cr is swallowed
    always_comb begin
        mode_eff = (mode == csvt_pkg::M_AFTER_CR) ? csvt_pkg::M_REC_START : mode;
        skip_lf  = (mode == csvt_pkg::M_AFTER_CR) && (text_byte == csvt_pkg::LF_BYTE);
    end

    always_comb begin
        step_mode = txt_mode;
        step_column = column;
        step_res = none_res;
        if (skip_lf) begin
            step_mode = csvt_pkg::M_REC_START;
        end else begin
            unique case (mode_eff)
                csvt_pkg::M_REC_START, csvt_pkg::M_FLD_START: begin
                    if (is_quote) begin
                        step_mode = csvt_pkg::M_QUOTED;
                    end else begin
                        step_mode = txt_mode;
                        step_column = txt_column;
                        step_res = txt_res;
                    end
                end
                csvt_pkg::M_QUOTED: begin
                    if (is_quote) begin
                        step_mode = csvt_pkg::M_QUOTE_SEEN;
                    end else begin
                        step_mode = csvt_pkg::M_QUOTED;
                        step_res = put_res;
                    end
                end
                csvt_pkg::M_QUOTE_SEEN: begin
                    if (is_quote) begin
                        step_mode = csvt_pkg::M_QUOTED;
                        step_res = put_res;
                    end else begin
                        step_mode = txt_mode;
                        step_column = txt_column;
                        step_res = txt_res;
                    end
                end
                default: begin
                    step_mode = txt_mode;
                    step_column = txt_column;
                    step_res = txt_res;
                end
            endcase
        end
    end

    // end of text closes any open record
    always_comb begin
        mode_next = step_mode;
        column_next = step_column;
        result = step_res;
        if (is_final) begin
            if (step_mode == csvt_pkg::M_IN_TEXT || step_mode == csvt_pkg::M_QUOTED ||
                step_mode == csvt_pkg::M_QUOTE_SEEN || step_mode == csvt_pkg::M_FLD_START) begin
                result.has = 1'b1;
                result.field_done = 1'b1;
                result.record_done = 1'b1;
                result.column_index = step_column;
            end
            mode_next = csvt_pkg::M_REC_START;
            column_next = '0;
        end
    end

endmodule

// ===== design/csv_byte_stream_tokenizer_core.sv =====
`timescale 1ns / 1ps
// csv tokenizer top level: input register, parse step and result register
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | s_valid s_ready s_text_byte s_is_final  | in
//  result  | m_valid m_ready m_byte_valid .. column  | out
//  config  | cfg_delimiter_we cfg_delimiter          | in
//
// one word per cycle sustained while m_ready holds; a word passes the input register, then the result register
// the parse mode and column counter update on the same edge as a word leaves the input register
// a word that yields no result only updates the parse state
// a stalled result register holds the input register; s_ready follows m_ready combinationally
// synchronous active-low reset clears valids, parse state and sets delimiter to comma
module csv_byte_stream_tokenizer_core (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_delimiter_we,
    input  logic [7:0]                 cfg_delimiter,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_text_byte,
    input  logic                       s_is_final,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_byte_valid,
    output logic [7:0]                 m_field_byte,
    output logic                       m_field_done,
    output logic                       m_record_done,
    output logic [csvt_pkg::COL_W-1:0] m_column_index
);

    logic [7:0]                  delimiter_reg;
    logic                        in_valid_reg;
    logic [7:0]                  in_byte_reg;
    logic                        in_final_reg;
    logic [csvt_pkg::MODE_W-1:0] mode_reg;
    logic [csvt_pkg::MODE_W-1:0] mode_next;
    logic [csvt_pkg::COL_W-1:0]  column_reg;
    logic [csvt_pkg::COL_W-1:0]  column_next;
    logic                        out_valid_reg;
    csvt_pkg::result_t           out_reg;
    csvt_pkg::result_t           step_res;
    logic                        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    csvt_step u_step (
        .mode        (mode_reg),
        .column      (column_reg),
        .delimiter   (delimiter_reg),
        .text_byte   (in_byte_reg),
        .is_final    (in_final_reg),
        .mode_next   (mode_next),
        .column_next (column_next),
        .result      (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= csvt_pkg::DELIM_RESET;
        end else if (cfg_delimiter_we) begin
            delimiter_reg <= cfg_delimiter;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg  <= s_text_byte;
            in_final_reg <= s_is_final;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= csvt_pkg::M_REC_START;
            column_reg <= '0;
        end else if (advance) begin
            mode_reg   <= mode_next;
            column_reg <= column_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_res.has;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= step_res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_byte_valid   = out_reg.byte_valid;
    assign m_field_byte   = out_reg.field_byte;
    assign m_field_done   = out_reg.field_done;
    assign m_record_done  = out_reg.record_done;
    assign m_column_index = out_reg.column_index;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// testbench for the csv tokenizer: random csv text, idle bursts, per-byte token prediction
module tb;

    typedef struct {
        logic [7:0] text;
        logic       fin;
    } text_word_t;

    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 50;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_delimiter_we = 1'b0;
    logic [7:0]                 cfg_delimiter = csvt_pkg::DELIM_RESET;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [7:0]                 s_text_byte = 8'h00;
    logic                       s_is_final = 1'b0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic                       m_byte_valid;
    logic [7:0]                 m_field_byte;
    logic                       m_field_done;
    logic                       m_record_done;
    logic [csvt_pkg::COL_W-1:0] m_column_index;

    text_word_t        text_q[$];
    csvt_pkg::result_t token_q[$];

    logic [csvt_pkg::MODE_W-1:0] parse_state = csvt_pkg::M_REC_START;
    logic [csvt_pkg::COL_W-1:0]  col_count = '0;
    logic [7:0]                  delim_q = csvt_pkg::DELIM_RESET;

    bit calm = 1'b0;
    int s_gap = 0;
    int m_gap = 0;
    int err_cnt = 0;
    int idle_cycles = 0;

    csv_byte_stream_tokenizer_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_delimiter_we (cfg_delimiter_we),
        .cfg_delimiter    (cfg_delimiter),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_text_byte      (s_text_byte),
        .s_is_final       (s_is_final),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_byte_valid     (m_byte_valid),
        .m_field_byte     (m_field_byte),
        .m_field_done     (m_field_done),
        .m_record_done    (m_record_done),
        .m_column_index   (m_column_index)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic tokenize_byte(input logic [7:0] b, input logic fin);
        csvt_pkg::result_t           r;
        logic [csvt_pkg::MODE_W-1:0] m;
        logic                        plain;
        logic                        swallow;
        r = '0;
        m = parse_state;
        plain = 1'b0;
        swallow = 1'b0;
        if (m == csvt_pkg::M_AFTER_CR) begin
            m = csvt_pkg::M_REC_START;
            swallow = (b == csvt_pkg::LF_BYTE);
        end
        if (!swallow) begin
            case (m)
                csvt_pkg::M_REC_START, csvt_pkg::M_FLD_START: begin
                    if (b == csvt_pkg::QUOTE_BYTE) m = csvt_pkg::M_QUOTED;
                    else plain = 1'b1;
                end
                csvt_pkg::M_QUOTED: begin
                    if (b == csvt_pkg::QUOTE_BYTE) begin
                        m = csvt_pkg::M_QUOTE_SEEN;
                    end else begin
                        r.has = 1'b1;
                        r.byte_valid = 1'b1;
                        r.field_byte = b;
                        r.column_index = col_count;
                    end
                end
                csvt_pkg::M_QUOTE_SEEN: begin
                    if (b == csvt_pkg::QUOTE_BYTE) begin
                        r.has = 1'b1;
                        r.byte_valid = 1'b1;
                        r.field_byte = b;
                        r.column_index = col_count;
                        m = csvt_pkg::M_QUOTED;
                    end else begin
                        plain = 1'b1;
                    end
                end
                default: plain = 1'b1;
            endcase
            if (plain) begin
                r.has = 1'b1;
                r.column_index = col_count;
                if (b == delim_q) begin
                    r.field_done = 1'b1;
                    if (col_count < csvt_pkg::COL_LIMIT) col_count = col_count + 1'b1;
                    m = csvt_pkg::M_FLD_START;
                end else if (b == csvt_pkg::CR_BYTE || b == csvt_pkg::LF_BYTE) begin
                    r.field_done = 1'b1;
                    r.record_done = 1'b1;
                    col_count = '0;
                    m = (b == csvt_pkg::CR_BYTE) ? csvt_pkg::M_AFTER_CR : csvt_pkg::M_REC_START;
                end else begin
                    r.byte_valid = 1'b1;
                    r.field_byte = b;
                    m = csvt_pkg::M_IN_TEXT;
                end
            end
        end
        if (fin) begin
            // end of text closes whatever field is still open
            if (m == csvt_pkg::M_IN_TEXT || m == csvt_pkg::M_QUOTED ||
                m == csvt_pkg::M_QUOTE_SEEN || m == csvt_pkg::M_FLD_START) begin
                r.has = 1'b1;
                r.field_done = 1'b1;
                r.record_done = 1'b1;
                r.column_index = col_count;
            end
            m = csvt_pkg::M_REC_START;
            col_count = '0;
        end
        parse_state = m;
        if (r.has) token_q.push_back(r);
    endtask

    task automatic check_field(input string name, input int unsigned exp, input int unsigned act);
        if (exp != act) begin
            if (err_cnt < MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, name, exp, act);
            err_cnt++;
        end
    endtask

    // driver
    always @(posedge aclk) begin : drive_text
        text_word_t w;
        logic       nxt_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_text_byte <= 8'h00;
            s_is_final <= 1'b0;
            s_gap = 0;
            parse_state = csvt_pkg::M_REC_START;
            col_count = '0;
        end else begin
            nxt_valid = s_valid;
            if (s_valid && s_ready) begin
                tokenize_byte(s_text_byte, s_is_final);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (!calm && $urandom_range(0, 15) == 0) begin
                    s_gap = $urandom_range(0, 17);
                end else if (text_q.size() > 0) begin
                    w = text_q.pop_front();
                    s_text_byte <= w.text;
                    s_is_final <= w.fin;
                    nxt_valid = 1'b1;
                end
            end
            s_valid <= nxt_valid;
        end
    end

    // monitor
    always @(posedge aclk) begin : watch_tokens
        csvt_pkg::result_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (token_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: token expected none actual byte %0h col %0d",
                                 $time, m_field_byte, m_column_index);
                    err_cnt++;
                end else begin
                    e = token_q.pop_front();
                    check_field("byte_valid", e.byte_valid, m_byte_valid);
                    check_field("field_byte", e.field_byte, m_field_byte);
                    check_field("field_done", e.field_done, m_field_done);
                    check_field("record_done", e.record_done, m_record_done);
                    check_field("column_index", e.column_index, m_column_index);
                end
            end
            if (m_gap > 0) begin
                m_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                m_gap = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_word(input logic [7:0] b, input logic fin);
        text_word_t w;
        w.text = b;
        w.fin = fin;
        text_q.push_back(w);
    endtask

    function automatic logic [7:0] any_byte();
        case ($urandom_range(0, 7))
            0: return csvt_pkg::QUOTE_BYTE;
            1: return delim_q;
            2: return csvt_pkg::CR_BYTE;
            3: return csvt_pkg::LF_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == csvt_pkg::QUOTE_BYTE || b == delim_q || b == csvt_pkg::CR_BYTE ||
               b == csvt_pkg::LF_BYTE)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic gen_records(input int n);
        int         nf;
        int         len;
        int         rec_start;
        logic [7:0] b;
        while (text_q.size() < n) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    push_word(any_byte(), $urandom_range(0, 15) == 0);
            end else begin
                rec_start = text_q.size();
                nf = $urandom_range(1, 6);
                for (int i = 0; i < nf; i++) begin
                    if (i > 0) push_word(delim_q, 1'b0);
                    case ($urandom_range(0, 3))
                        0: ;
                        1, 2: begin
                            len = $urandom_range(1, 6);
                            for (int j = 0; j < len; j++)
                                push_word((j > 0 && $urandom_range(0, 9) == 0) ?
                                          csvt_pkg::QUOTE_BYTE : plain_byte(), 1'b0);
                        end
                        default: begin
                            push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
                            len = $urandom_range(0, 5);
                            for (int j = 0; j < len; j++) begin
                                if ($urandom_range(0, 4) == 0) begin
                                    push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
                                    push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
                                end else begin
                                    b = any_byte();
                                    if (b == csvt_pkg::QUOTE_BYTE) b = 8'h00;
                                    push_word(b, 1'b0);
                                end
                            end
                            if ($urandom_range(0, 19) != 0) begin
                                push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
                                if ($urandom_range(0, 4) == 0) push_word(plain_byte(), 1'b0);
                            end
                        end
                    endcase
                end
                case ($urandom_range(0, 4))
                    0: push_word(csvt_pkg::CR_BYTE, 1'b0);
                    1: push_word(csvt_pkg::LF_BYTE, 1'b0);
                    2: begin
                        push_word(csvt_pkg::CR_BYTE, 1'b0);
                        push_word(csvt_pkg::LF_BYTE, 1'b0);
                    end
                    3: push_word(csvt_pkg::LF_BYTE, 1'b0);
                    default: begin
                        if (text_q.size() > rec_start) text_q[$].fin = 1'b1;
                        else push_word(csvt_pkg::LF_BYTE, 1'b1);
                    end
                endcase
            end
        end
        text_q[$].fin = 1'b1;
    endtask

    task automatic wait_drained();
        do @(negedge aclk); while (text_q.size() != 0 || s_valid || token_q.size() != 0);
    endtask

    task automatic set_delimiter(input logic [7:0] d);
        wait_drained();
        repeat (8) @(posedge aclk);
        cfg_delimiter_we <= 1'b1;
        cfg_delimiter <= d;
        @(posedge aclk);
        cfg_delimiter_we <= 1'b0;
        delim_q = d;
        @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // blank lines, crlf swallow, lf then cr
        push_word(csvt_pkg::LF_BYTE, 1'b0);
        push_word(csvt_pkg::CR_BYTE, 1'b0);
        push_word(csvt_pkg::LF_BYTE, 1'b0);
        push_word(csvt_pkg::LF_BYTE, 1'b0);
        push_word(csvt_pkg::CR_BYTE, 1'b0);
        push_word(8'h00, 1'b0);
        push_word(8'hFF, 1'b0);
        push_word(csvt_pkg::DELIM_RESET, 1'b0);
        // quoted field with doubled quote and trailing text
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word("a", 1'b0);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word("b", 1'b0);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word("x", 1'b0);
        push_word(csvt_pkg::CR_BYTE, 1'b0);
        // text ending on a delimiter
        push_word("z", 1'b0);
        push_word(csvt_pkg::DELIM_RESET, 1'b1);
        // text ending on a closing quote, then on a lone opening quote
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word("q", 1'b0);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b1);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b1);
        push_word("k", 1'b1);
        // unterminated quotes run to the end
        push_word(csvt_pkg::DELIM_RESET, 1'b0);
        push_word(csvt_pkg::QUOTE_BYTE, 1'b0);
        push_word("u", 1'b0);
        push_word(csvt_pkg::LF_BYTE, 1'b1);
        gen_records(text_q.size() + 8);

        set_delimiter(csvt_pkg::QUOTE_BYTE);
        gen_records(8);
        set_delimiter(csvt_pkg::CR_BYTE);
        gen_records(8);
        set_delimiter(csvt_pkg::LF_BYTE);
        gen_records(8);
        set_delimiter(8'h00);
        gen_records(8);
        set_delimiter(8'hFF);
        gen_records(8);

        // column counter saturation
        set_delimiter(8'h7C);
        for (int i = 0; i < 1024; i++) push_word(8'h7C, 1'b0);
        push_word("e", 1'b0);
        push_word(csvt_pkg::LF_BYTE, 1'b0);
        gen_records(text_q.size() + 4);

        set_delimiter(8'($urandom_range(0, 255)));
        gen_records(8);

        set_delimiter(csvt_pkg::DELIM_RESET);
        calm = 1'b1;
        gen_records(16);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

// ===== csv_byte_stream_tokenizer_core.f =====
design/csvt_pkg.sv
design/csvt_step.sv
design/csv_byte_stream_tokenizer_core.sv
test/tb.sv
